/* src/nrt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nrt_pkg
// Shared types and codes of the node reservation timeline.
// ----------------------------------------------------------------------------
package nrt_pkg;

  localparam int TIME_W  = 32;
  localparam int MASK_W  = 64;
  localparam int LIMIT_W = 6;

  localparam logic [1:0] REQ_INIT    = 2'd0;
  localparam logic [1:0] REQ_TEST    = 2'd1;
  localparam logic [1:0] REQ_RESERVE = 2'd2;
  localparam logic [1:0] REQ_QUERY   = 2'd3;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd50;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [TIME_W-1:0] win_start;
    logic [TIME_W-1:0] win_end;
    logic [MASK_W-1:0] node_mask;
  } req_t;

  typedef struct packed {
    logic              status;
    logic              overlap;
    logic [MASK_W-1:0] avail_mask;
    logic [TIME_W-1:0] later_time;
    logic              later_valid;
  } res_t;

endpackage
`default_nettype wire

/* src/nrt_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nrt_req_if
// Request channel: valid/ready with the request fields.
// ----------------------------------------------------------------------------
interface nrt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] win_start;
  logic [31:0] win_end;
  logic [63:0] node_mask;

  modport source (output valid, req_type, win_start, win_end, node_mask, input ready);
  modport sink   (input valid, req_type, win_start, win_end, node_mask, output ready);
endinterface
`default_nettype wire

/* src/nrt_res_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nrt_res_if
// Result channel: valid/ready with the result fields.
// ----------------------------------------------------------------------------
interface nrt_res_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        overlap;
  logic [63:0] avail_mask;
  logic [31:0] later_time;
  logic        later_valid;

  modport source (output valid, status, overlap, avail_mask, later_time, later_valid,
                  input ready);
  modport sink   (input valid, status, overlap, avail_mask, later_time, later_valid,
                  output ready);
endinterface
`default_nettype wire

/* src/nrt_rec_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nrt_rec_mem
// Interval record store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nrt_rec_mem #(
  parameter int DEPTH = 64,
  parameter int W     = 134
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/nrt_walker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nrt_walker
// Sequencer that walks the linked record list one record per read and
// applies init, test, reserve and query with one compare/update unit.
// ----------------------------------------------------------------------------
module nrt_walker #(
  parameter int DEPTH = 64,
  parameter int NODES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         go,
  input  wire nrt_pkg::req_t                req,
  input  wire logic [nrt_pkg::LIMIT_W-1:0]  limit,
  output logic                              busy,
  output logic                              res_valid,
  input  wire logic                         res_take,
  output nrt_pkg::res_t                     res
);
  import nrt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = AW + NODES + 2 * TIME_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_WN   = 3'd3;
  localparam logic [2:0] S_W2   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [1:0] PH_FIND = 2'd0;
  localparam logic [1:0] PH_NEXT = 2'd1;
  localparam logic [1:0] PH_MASK = 2'd2;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [1:0]        typ_r, typ_nxt;
  logic [TIME_W-1:0] st_r, st_nxt, en_r, en_nxt;
  logic [NODES-1:0]  mask_r, mask_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [TIME_W-1:0] pb_r, pb_nxt, pe_r, pe_nxt;
  logic [NODES-1:0]  pf_r, pf_nxt;
  logic [AW-1:0]     pl_r, pl_nxt;
  logic              status_r, status_nxt, ovl_r, ovl_nxt, lv_r, lv_nxt;
  logic [NODES-1:0]  avail_r, avail_nxt;
  logic [TIME_W-1:0] later_r, later_nxt;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [RW-1:0]     wdata, rdata;
  logic [TIME_W-1:0] rb, re;
  logic [NODES-1:0]  rf;
  logic [AW-1:0]     rl;
  logic              split2;
  logic [31:0]       cnt_ext, lim_ext;

  nrt_rec_mem #(.DEPTH(DEPTH), .W(RW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr_r),
    .rdata (rdata)
  );

  assign {rl, rf, re, rb} = rdata;
  assign split2  = en_r < pe_r;
  assign cnt_ext = 32'(count_r);
  assign lim_ext = 32'(limit);

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    typ_nxt    = typ_r;
    st_nxt     = st_r;
    en_nxt     = en_r;
    mask_nxt   = mask_r;
    count_nxt  = count_r;
    addr_nxt   = addr_r;
    pb_nxt     = pb_r;
    pe_nxt     = pe_r;
    pf_nxt     = pf_r;
    pl_nxt     = pl_r;
    status_nxt = status_r;
    ovl_nxt    = ovl_r;
    lv_nxt     = lv_r;
    avail_nxt  = avail_r;
    later_nxt  = later_r;
    we         = 1'b0;
    waddr      = addr_r;
    wdata      = {rl, rf, re, rb};
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          typ_nxt    = req.req_type;
          st_nxt     = req.win_start;
          en_nxt     = req.win_end;
          mask_nxt   = req.node_mask[NODES-1:0];
          status_nxt = STATUS_DONE;
          ovl_nxt    = 1'b0;
          lv_nxt     = 1'b0;
          later_nxt  = '0;
          avail_nxt  = (req.req_type == REQ_QUERY) ? req.node_mask[NODES-1:0] : '0;
          addr_nxt   = '0;
          phase_nxt  = PH_FIND;
          state_nxt  = S_RD;
          if (req.req_type == REQ_INIT) begin
            we        = 1'b1;
            waddr     = '0;
            wdata     = {{AW{1'b0}}, req.node_mask[NODES-1:0], req.win_end,
                         req.win_start};
            count_nxt = CW'(1);
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            state_nxt = S_DONE;
          end else if (req.req_type == REQ_RESERVE &&
                       (cnt_ext >= lim_ext || cnt_ext + 32'd2 > 32'(DEPTH))) begin
            status_nxt = STATUS_FULL;
            state_nxt  = S_DONE;
          end
        end
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        state_nxt = S_RD;
        addr_nxt  = rl;
        unique case (typ_r)
          REQ_TEST: begin
            if (re > st_r && rb < en_r && (mask_r & ~rf) != '0) begin
              ovl_nxt   = 1'b1;
              state_nxt = S_DONE;
            end else if (rl == '0) begin
              state_nxt = S_DONE;
            end
          end
          REQ_QUERY: begin
            if (re > st_r && rl != '0 && !lv_r) begin
              later_nxt = re;
              lv_nxt    = 1'b1;
            end
            if (re > st_r && rb > en_r) begin
              state_nxt = S_DONE;
            end else begin
              if (re > st_r) avail_nxt = avail_r & rf;
              if (rl == '0) state_nxt = S_DONE;
            end
          end
          default: begin
            unique case (phase_r)
              PH_FIND: begin
                if (re > st_r) begin
                  we        = 1'b1;
                  wdata     = {AW'(count_r), rf, st_r, rb};
                  pb_nxt    = st_r;
                  pe_nxt    = re;
                  pf_nxt    = rf;
                  pl_nxt    = rl;
                  state_nxt = S_WN;
                end else if (re == st_r && rl != '0) begin
                  phase_nxt = PH_NEXT;
                end else if (re == st_r || rl == '0) begin
                  phase_nxt = PH_MASK;
                  addr_nxt  = '0;
                end
              end
              PH_NEXT: begin
                if (en_r < re) begin
                  we        = 1'b1;
                  wdata     = {AW'(count_r), rf, en_r, rb};
                  pb_nxt    = en_r;
                  pe_nxt    = re;
                  pf_nxt    = rf;
                  pl_nxt    = rl;
                  state_nxt = S_W2;
                end else begin
                  phase_nxt = PH_MASK;
                  addr_nxt  = '0;
                end
              end
              default: begin
                if (rb >= st_r && re <= en_r) begin
                  we    = 1'b1;
                  wdata = {rl, rf & mask_r, re, rb};
                end
                if (rb >= en_r || rl == '0) state_nxt = S_DONE;
              end
            endcase
          end
        endcase
      end
      S_WN: begin
        we        = 1'b1;
        waddr     = AW'(count_r);
        count_nxt = count_r + CW'(1);
        if (split2) begin
          wdata     = {AW'(count_r + CW'(1)), pf_r, en_r, pb_r};
          pb_nxt    = en_r;
          state_nxt = S_W2;
        end else begin
          wdata     = {pl_r, pf_r, pe_r, pb_r};
          phase_nxt = PH_MASK;
          addr_nxt  = '0;
          state_nxt = S_RD;
        end
      end
      S_W2: begin
        we        = 1'b1;
        waddr     = AW'(count_r);
        wdata     = {pl_r, pf_r, pe_r, pb_r};
        count_nxt = count_r + CW'(1);
        phase_nxt = PH_MASK;
        addr_nxt  = '0;
        state_nxt = S_RD;
      end
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    phase_r  <= phase_nxt;
    typ_r    <= typ_nxt;
    st_r     <= st_nxt;
    en_r     <= en_nxt;
    mask_r   <= mask_nxt;
    addr_r   <= addr_nxt;
    pb_r     <= pb_nxt;
    pe_r     <= pe_nxt;
    pf_r     <= pf_nxt;
    pl_r     <= pl_nxt;
    status_r <= status_nxt;
    ovl_r    <= ovl_nxt;
    lv_r     <= lv_nxt;
    avail_r  <= avail_nxt;
    later_r  <= later_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign res_valid = state_r == S_DONE;
  assign res.status      = status_r;
  assign res.overlap     = ovl_r;
  assign res.avail_mask  = MASK_W'(avail_r);
  assign res.later_time  = later_r;
  assign res.later_valid = lv_r;

endmodule
`default_nettype wire

/* src/node_reservation_timeline.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// node_reservation_timeline
// Time-ordered table of interval records with free-node masks.
// ----------------------------------------------------------------------------
// One request at a time. Test, query and accepted reserve requests on a
// non-empty table walk the linked record list through a single registered
// memory read port; a reservation splits at most two records and walks the
// list twice (locate, then mask). A finished result moves to the output
// register once free, so the next request is taken while it waits. Write
// record_limit via cfg_we/cfg_wdata when idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module node_reservation_timeline #(
  parameter int TABLE_DEPTH = 64,
  parameter int NODE_COUNT  = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  nrt_req_if.sink                          in_ch,
  nrt_res_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [nrt_pkg::LIMIT_W-1:0] cfg_wdata
);
  import nrt_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic               out_valid_r;
  res_t               out_r;
  res_t               res;
  logic               busy, res_valid, res_take;
  req_t               req;

  assign req.req_type  = in_ch.req_type;
  assign req.win_start = in_ch.win_start;
  assign req.win_end   = in_ch.win_end;
  assign req.node_mask = in_ch.node_mask;

  assign in_ch.ready = !busy;
  assign res_take    = res_valid && (!out_valid_r || out_ch.ready);

  nrt_walker #(.DEPTH(TABLE_DEPTH), .NODES(NODE_COUNT)) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (in_ch.valid && !busy),
    .req       (req),
    .limit     (limit_r),
    .busy      (busy),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_take) out_r <= res;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.overlap     = out_r.overlap;
  assign out_ch.avail_mask  = out_r.avail_mask;
  assign out_ch.later_time  = out_r.later_time;
  assign out_ch.later_valid = out_r.later_valid;

endmodule
`default_nettype wire

/* src/nrt_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nrt_checker
// Port-level checks on the result channel of the timeline.
// ----------------------------------------------------------------------------
module nrt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        status,
  input wire logic        overlap,
  input wire logic [63:0] avail_mask,
  input wire logic [31:0] later_time,
  input wire logic        later_valid
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(avail_mask))
    else $error("result dropped or changed while stalled");

  a_later: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !later_valid |-> later_time == 32'd0)
    else $error("later_time set without later_valid");

  a_overlap_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overlap |-> !status && !later_valid && avail_mask == 64'd0)
    else $error("test result mixed with other results");

  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> !overlap && !later_valid && avail_mask == 64'd0)
    else $error("refusal mixed with other results");

endmodule

bind node_reservation_timeline nrt_checker u_nrt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .overlap     (out_ch.overlap),
  .avail_mask  (out_ch.avail_mask),
  .later_time  (out_ch.later_time),
  .later_valid (out_ch.later_valid)
);
`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for node_reservation_timeline: directed rows, then
// random init/reserve/test/query traffic checked against a local model of
// the interval table, under varying back-pressure and record limits.
// ----------------------------------------------------------------------------
module tb_top;
  import nrt_pkg::*;

  localparam int DEPTH    = 64;
  localparam int WD_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  nrt_req_if in_ch ();
  nrt_res_if out_ch ();

  node_reservation_timeline #(.TABLE_DEPTH(DEPTH), .NODE_COUNT(64)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // timeline copy
  logic [31:0] tl_begin [DEPTH];
  logic [31:0] tl_end [DEPTH];
  logic [63:0] tl_free [DEPTH];
  int          tl_link [DEPTH];
  int          tl_count;
  int          tl_limit;

  res_t answer_q[$];
  int   errors;
  int   idle_in_pct;
  int   idle_out_pct;
  bit   hold_out;
  int   quiet_cycles;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void tl_split(input int j, input logic [31:0] t);
    int i;
    i = tl_count;
    if (i >= DEPTH) return;
    tl_begin[i] = t;
    tl_end[i]   = tl_end[j];
    tl_end[j]   = t;
    tl_free[i]  = tl_free[j];
    tl_link[i]  = tl_link[j];
    tl_link[j]  = i;
    tl_count++;
  endfunction

  function automatic void tl_reserve(input logic [31:0] st, input logic [31:0] en,
                                     input logic [63:0] keep);
    int j;
    bit placed;
    j = 0;
    placed = 0;
    for (int n = 0; n < DEPTH; n++) begin
      if (tl_end[j] > st) begin
        tl_split(j, st);
        placed = 1;
      end
      if (tl_end[j] == st) placed = 1;
      if (placed) begin
        j = tl_link[j];
        if (j != 0 && en < tl_end[j]) tl_split(j, en);
        break;
      end
      j = tl_link[j];
      if (j == 0) break;
    end
    j = 0;
    for (int n = 0; n < DEPTH; n++) begin
      if (tl_begin[j] >= st && tl_end[j] <= en) tl_free[j] &= keep;
      if (tl_begin[j] >= en) break;
      j = tl_link[j];
      if (j == 0) break;
    end
  endfunction

  function automatic res_t tl_apply(input req_t r);
    res_t o;
    int   j;
    o = '0;
    case (r.req_type)
      REQ_INIT: begin
        tl_begin[0] = r.win_start;
        tl_end[0]   = r.win_end;
        tl_free[0]  = r.node_mask;
        tl_link[0]  = 0;
        tl_count    = 1;
      end
      REQ_TEST: begin
        if (tl_count != 0) begin
          j = 0;
          for (int n = 0; n < DEPTH; n++) begin
            if (tl_end[j] > r.win_start && tl_begin[j] < r.win_end &&
                (r.node_mask & ~tl_free[j]) != 0) begin
              o.overlap = 1'b1;
              break;
            end
            j = tl_link[j];
            if (j == 0) break;
          end
        end
      end
      REQ_RESERVE: begin
        if (tl_count != 0) begin
          if (tl_count >= tl_limit || tl_count + 2 > DEPTH) o.status = STATUS_FULL;
          else tl_reserve(r.win_start, r.win_end, r.node_mask);
        end
      end
      default: begin
        o.avail_mask = r.node_mask;
        if (tl_count != 0) begin
          j = 0;
          for (int n = 0; n < DEPTH; n++) begin
            if (tl_end[j] > r.win_start && tl_link[j] != 0 && !o.later_valid) begin
              o.later_time  = tl_end[j];
              o.later_valid = 1'b1;
            end
            if (tl_end[j] > r.win_start) begin
              if (tl_begin[j] <= r.win_end) o.avail_mask &= tl_free[j];
              else break;
            end
            j = tl_link[j];
            if (j == 0) break;
          end
        end
      end
    endcase
    return o;
  endfunction

  task automatic send(input req_t r);
    while (idle_in_pct != 0 && $urandom_range(99) < idle_in_pct) @(posedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= r.req_type;
    in_ch.win_start <= r.win_start;
    in_ch.win_end   <= r.win_end;
    in_ch.node_mask <= r.node_mask;
    answer_q.push_back(tl_apply(r));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (answer_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_limit(input int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[LIMIT_W-1:0];
    tl_limit  = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_time();
    case ($urandom_range(3))
      0: return $urandom_range(40);
      1: return $urandom;
      2: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom_range(1000);
    endcase
  endfunction

  function automatic logic [63:0] rnd_mask();
    case ($urandom_range(3))
      0: return '1;
      1: return '1 ^ (64'd1 << $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic req_t rnd_req(input int init_pct);
    req_t r;
    logic [31:0] a, b;
    a = rnd_time();
    b = rnd_time();
    r.req_type = ($urandom_range(99) < init_pct) ? REQ_INIT : 2'($urandom_range(1, 3));
    if (r.req_type != REQ_INIT && $urandom_range(99) < 60) r.req_type = REQ_RESERVE;
    if ($urandom_range(9) != 0 && a > b) begin
      r.win_start = b;
      r.win_end = a;
    end else begin
      r.win_start = a;
      r.win_end = b;
    end
    r.node_mask = rnd_mask();
    return r;
  endfunction

  // result side
  always @(posedge clk) begin
    res_t w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          report("unexpected transfer", 64'd0, 64'd0);
        end else begin
          w = answer_q.pop_front();
          if (out_ch.status !== w.status) report("status", out_ch.status, w.status);
          if (out_ch.overlap !== w.overlap) report("overlap", out_ch.overlap, w.overlap);
          if (out_ch.avail_mask !== w.avail_mask)
            report("avail_mask", out_ch.avail_mask, w.avail_mask);
          if (out_ch.later_time !== w.later_time)
            report("later_time", out_ch.later_time, w.later_time);
          if (out_ch.later_valid !== w.later_valid)
            report("later_valid", out_ch.later_valid, w.later_valid);
        end
      end
      out_ch.ready <= !hold_out && !(idle_out_pct != 0 && $urandom_range(99) < idle_out_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (!in_ch.valid && answer_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("node_reservation_timeline regression: fail");
        $finish;
      end
    end
  end

  req_t dir_rows [$];
  res_t dir_want [$];
  bit   dir_has [$];

  task automatic row(input logic [1:0] t, input logic [31:0] s, input logic [31:0] e,
                     input logic [63:0] m, input bit has, input res_t w);
    req_t r;
    r.req_type = t;
    r.win_start = s;
    r.win_end = e;
    r.node_mask = m;
    dir_rows.push_back(r);
    dir_has.push_back(has);
    dir_want.push_back(w);
  endtask

  // directed row: send and, where the answer is typed in, check the model agrees
  task automatic tl_reset_undo(input int k, input res_t predicted);
    res_t w;
    w = predicted;
    if (dir_has[k] && predicted !== dir_want[k]) begin
      report("directed row", 64'(k), 64'(0));
      w = dir_want[k];
    end
    while (idle_in_pct != 0 && $urandom_range(99) < idle_in_pct) @(posedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= dir_rows[k].req_type;
    in_ch.win_start <= dir_rows[k].win_start;
    in_ch.win_end   <= dir_rows[k].win_end;
    in_ch.node_mask <= dir_rows[k].node_mask;
    answer_q.push_back(w);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_fixed(input logic [1:0] t, input logic [31:0] s, input logic [31:0] e,
                            input logic [63:0] m);
    req_t r;
    r.req_type = t;
    r.win_start = s;
    r.win_end = e;
    r.node_mask = m;
    send(r);
  endtask

  initial begin
    res_t none;
    res_t z;
    res_t p;
    int   lims [6];
    none = '0;
    errors = 0;
    hold_out = 0;
    idle_in_pct = 0;
    idle_out_pct = 0;
    tl_count = 0;
    tl_limit = LIMIT_RESET;
    for (int k = 0; k < DEPTH; k++) begin
      tl_begin[k] = '0; tl_end[k] = '0; tl_free[k] = '0; tl_link[k] = 0;
    end
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_INIT;
    in_ch.win_start = '0;
    in_ch.win_end = '0;
    in_ch.node_mask = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table
    row(REQ_TEST, 0, 32'hFFFF_FFFF, '1, 1, none);
    row(REQ_RESERVE, 5, 10, '0, 1, none);
    z = none; z.avail_mask = 64'hA5A5_5A5A_0F0F_F0F0;
    row(REQ_QUERY, 0, 100, 64'hA5A5_5A5A_0F0F_F0F0, 1, z);
    row(REQ_INIT, 0, 32'hFFFF_FFFF, '1, 1, none);
    row(REQ_RESERVE, 100, 200, 64'h0000_0000_FFFF_FFFF, 0, none);
    row(REQ_TEST, 150, 160, 64'h1_0000_0000, 0, none);
    row(REQ_TEST, 150, 160, 64'h1, 0, none);
    row(REQ_QUERY, 0, 32'hFFFF_FFFF, '1, 0, none);
    row(REQ_QUERY, 150, 150, '1, 0, none);
    row(REQ_RESERVE, 200, 100, '0, 0, none);
    row(REQ_RESERVE, 300, 300, 64'h8000_0000_0000_0000, 0, none);
    row(REQ_RESERVE, 0, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 0, none);
    row(REQ_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 0, none);
    row(REQ_TEST, 32'hFFFF_FFFF, 0, '1, 0, none);
    row(REQ_INIT, 32'hFFFF_FFFF, 0, '0, 1, none);
    row(REQ_QUERY, 0, 0, '1, 0, none);
    row(REQ_RESERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 0, none);
    for (int k = 0; k < dir_rows.size(); k++) begin
      p = tl_apply(dir_rows[k]);
      tl_reset_undo(k, p);
    end

    // limit of one: reservations refused
    set_limit(1);
    send_fixed(REQ_INIT, 0, 1000, '1);
    send_fixed(REQ_RESERVE, 10, 20, '0);
    set_limit(61);

    lims[0] = 1; lims[1] = 61; lims[2] = 4; lims[3] = 50; lims[4] = 20; lims[5] = 61;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) set_limit(lims[ph]);
      idle_in_pct  = (ph < 2) ? 28 : (ph < 4) ? 49 : 0;
      idle_out_pct = (ph < 2) ? 49 : (ph < 4) ? 28 : 0;
      for (int k = 0; k < 135; k++) send(rnd_req(4));
      if (ph == 2) begin
        fork
          begin
            hold_out = 1;
            repeat (600) @(posedge clk);
            hold_out = 0;
          end
          for (int k = 0; k < 12; k++) send(rnd_req(0));
        join
        drain();
      end
    end

    drain();
    if (errors == 0) $display("node_reservation_timeline regression: pass");
    else $display("node_reservation_timeline regression: fail");
    $finish;
  end

endmodule
